// ===== sv/csad_pkg.sv =====
// Shared types, codes and reset constants for the capture stream A/V demux.
// No dependencies; used by every csad_* module and the top level.
package csad_pkg;

    localparam int unsigned COUNT_WIDTH_DEF = 24;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned FRAME_W  = 24;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [WORD_W-1:0]  VIDEO_END_RST   = 32'hC1FF_FF00;
    localparam logic [WORD_W-1:0]  AUDIO_START_RST = 32'h58FF_FF00;
    localparam logic [WORD_W-1:0]  AUDIO_END_RST   = 32'h0000_0000;
    localparam logic [FRAME_W-1:0] MIN_WORDS_RST   = 24'h00_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VIDEO_END   = 2'd0,
        CFG_AUDIO_START = 2'd1,
        CFG_AUDIO_END   = 2'd2,
        CFG_MIN_WORDS   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_VIDEO     = 2'd0,
        KIND_AUDIO     = 2'd1,
        KIND_VIDEO_END = 2'd2,
        KIND_AUDIO_END = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        MODE_VIDEO = 2'd0,
        MODE_PAD   = 2'd1,
        MODE_AUDIO = 2'd2
    } t_mode;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_words;
        t_kind              kind;
        logic [WORD_W-1:0]  out_word;
    } t_result;

endpackage

// ===== sv/csad_front.sv =====
// Front end: takes capture words, tracks mode and video count, classifies
// each word and pushes at most one result into the queue. Uses csad_pkg.
module csad_front #(
    parameter int unsigned COUNT_WIDTH = csad_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [csad_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [csad_pkg::WORD_W-1:0]       i_cfg_data,
    input  logic                              i_valid,
    input  logic [csad_pkg::WORD_W-1:0]       i_word,
    input  logic                              i_room,
    output logic                              o_ready,
    output logic                              o_push,
    output csad_pkg::t_result                 o_item
);

    localparam int unsigned EXT_W = 33;

    logic [csad_pkg::WORD_W-1:0]  r_video_end;
    logic [csad_pkg::WORD_W-1:0]  r_audio_start;
    logic [csad_pkg::WORD_W-1:0]  r_audio_end;
    logic [csad_pkg::FRAME_W-1:0] r_min_words;

    csad_pkg::t_mode        r_mode, n_mode;
    logic [COUNT_WIDTH-1:0] r_count, n_count;

    logic                   accept;
    logic [EXT_W-1:0]       count_ext;
    logic                   frame_ok;
    logic [csad_pkg::FRAME_W-1:0] frame_clamped;

    assign o_ready = i_room;
    assign accept  = i_valid && i_room;

    assign count_ext = EXT_W'(r_count);
    assign frame_ok  = count_ext >= EXT_W'(r_min_words);
    // count may be wider than the reported field: clamp
    assign frame_clamped = (count_ext > EXT_W'({csad_pkg::FRAME_W{1'b1}}))
                         ? {csad_pkg::FRAME_W{1'b1}}
                         : count_ext[csad_pkg::FRAME_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_end   <= csad_pkg::VIDEO_END_RST;
            r_audio_start <= csad_pkg::AUDIO_START_RST;
            r_audio_end   <= csad_pkg::AUDIO_END_RST;
            r_min_words   <= csad_pkg::MIN_WORDS_RST;
        end else if (i_cfg_we) begin
            unique case (csad_pkg::t_cfg_idx'(i_cfg_idx))
                csad_pkg::CFG_VIDEO_END:   r_video_end   <= i_cfg_data;
                csad_pkg::CFG_AUDIO_START: r_audio_start <= i_cfg_data;
                csad_pkg::CFG_AUDIO_END:   r_audio_end   <= i_cfg_data;
                csad_pkg::CFG_MIN_WORDS:   r_min_words   <= i_cfg_data[csad_pkg::FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= csad_pkg::MODE_VIDEO;
            r_count <= '0;
        end else begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_mode             = r_mode;
        n_count            = r_count;
        o_push             = 1'b0;
        o_item.out_word    = '0;
        o_item.kind        = csad_pkg::KIND_VIDEO;
        o_item.frame_words = '0;
        if (accept) begin
            unique case (r_mode)
                csad_pkg::MODE_PAD: begin
                    // padding word is dropped whatever its value
                    n_mode = csad_pkg::MODE_AUDIO;
                end
                csad_pkg::MODE_AUDIO: begin
                    o_push = 1'b1;
                    if (i_word == r_audio_end) begin
                        n_mode      = csad_pkg::MODE_VIDEO;
                        o_item.kind = csad_pkg::KIND_AUDIO_END;
                    end else begin
                        o_item.kind     = csad_pkg::KIND_AUDIO;
                        o_item.out_word = i_word;
                    end
                end
                default: begin
                    // video mode; the unused code behaves the same
                    n_mode = csad_pkg::MODE_VIDEO;
                    if (i_word == r_video_end) begin
                        if (frame_ok) begin
                            o_push             = 1'b1;
                            o_item.kind        = csad_pkg::KIND_VIDEO_END;
                            o_item.frame_words = frame_clamped;
                            n_count            = '0;
                        end
                    end else if (i_word == r_audio_start) begin
                        n_mode = csad_pkg::MODE_PAD;
                    end else begin
                        if (r_count != {COUNT_WIDTH{1'b1}}) begin
                            n_count = r_count + COUNT_WIDTH'(1);
                        end
                        o_push          = 1'b1;
                        o_item.out_word = i_word;
                    end
                end
            endcase
        end
    end

    a_pad_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_mode == csad_pkg::MODE_PAD) |-> !o_push)
        else $error("padding word produced a result");

    a_pad_to_audio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_mode == csad_pkg::MODE_PAD) |=> (r_mode == csad_pkg::MODE_AUDIO))
        else $error("padding skip did not enter audio mode");

    a_frame_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_item.kind == csad_pkg::KIND_VIDEO_END) |=> (r_count == '0))
        else $error("video count not cleared after frame end");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (i_room && i_valid))
        else $error("push without accepted word");

endmodule

// ===== sv/csad_queue.sv =====
// Short result queue between the front and back ends.
// Register-based FIFO of csad_pkg::t_result entries.
module csad_queue #(
    parameter int unsigned DEPTH = csad_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  csad_pkg::t_result i_item,
    input  logic              i_pop,
    output logic              o_room,
    output logic              o_nonempty,
    output csad_pkg::t_result o_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    csad_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_room     = r_count != CNT_W'(DEPTH);
    assign o_nonempty = r_count != '0;
    assign o_item     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= next_ptr(r_wr_ptr);
            if (i_pop)  r_rd_ptr <= next_ptr(r_rd_ptr);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_room)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_nonempty)
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== sv/csad_back.sv =====
// Back end: output register that drains the result queue onto the
// master stream and packs result fields. Uses csad_pkg.
module csad_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_nonempty,
    input  csad_pkg::t_result i_item,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [55:0]       o_data,
    output logic [1:0]        o_user
);

    logic              r_valid;
    csad_pkg::t_result r_item;

    // refill when empty or the held request is taken this cycle
    assign o_pop = i_nonempty && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {r_item.frame_words, r_item.out_word};
    assign o_user  = r_item.kind;

endmodule

// ===== sv/capture_stream_av_demux.sv =====
// Top level of the capture stream A/V demux: front end, result queue, back end.
// Depends on csad_pkg, csad_front, csad_queue, csad_back.
//
// Channel   Dir  Signals                       Contents
// s_axis    in   tvalid/tready/tdata[31:0]     word
// m_axis    out  tvalid/tready/tdata/tuser     tdata: out_word, frame_words; tuser: kind
// cfg       in   we/idx[1:0]/data[31:0]        marker and min size registers
//
// One capture word is taken per clock while the result queue has room.
// A result is written into the queue when its word is taken and then moves to
// the output register, from which it shows on m_axis; padding, audio start
// and short-frame end markers produce no result. Input tready drops only when
// the queue is full, i.e. after QUEUE_DEPTH results wait behind a stalled output.
// Synchronous active-low reset returns to video mode with a zero count.
module capture_stream_av_demux #(
    parameter int unsigned COUNT_WIDTH = csad_pkg::COUNT_WIDTH_DEF,
    parameter int unsigned QUEUE_DEPTH = csad_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] word
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // [31:0] out_word, [55:32] frame_words
    output logic [1:0]  o_m_axis_tuser    // [1:0] kind
);

    logic              push, room, pop, nonempty;
    csad_pkg::t_result push_item, head_item;

    csad_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_axis_tvalid),
        .i_word     (i_s_axis_tdata),
        .i_room     (room),
        .o_ready    (o_s_axis_tready),
        .o_push     (push),
        .o_item     (push_item)
    );

    csad_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (push_item),
        .i_pop      (pop),
        .o_room     (room),
        .o_nonempty (nonempty),
        .o_item     (head_item)
    );

    csad_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (nonempty),
        .i_item     (head_item),
        .o_pop      (pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_data     (o_m_axis_tdata),
        .o_user     (o_m_axis_tuser)
    );

endmodule
